// File: sv/hcsp_pkg.sv
package hcsp_pkg;

    localparam int unsigned MaxDigits  = 16;
    localparam int unsigned StoreDepth = 8;
    localparam int unsigned CountW     = 5;
    localparam int unsigned IdxW       = 3;

    localparam logic [7:0]  CharEnd    = 8'h00;
    localparam logic [15:0] AlphaOpaque = 16'hFFFF;

    localparam logic [CountW-1:0] CntShort = CountW'(6);
    localparam logic [CountW-1:0] CntByteA = CountW'(8);
    localparam logic [CountW-1:0] CntWide  = CountW'(12);
    localparam logic [CountW-1:0] CntFull  = CountW'(MaxDigits);

    typedef enum logic {
        ST_OK    = 1'b0,
        ST_SHORT = 1'b1
    } status_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nib;
    } hex_digit_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } color_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.is_hex = 1'b1;
        d.nib    = 4'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.nib = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.nib = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.nib = 4'(c - 8'h37);
        end
        else
        begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: sv/hcsp_scan.sv
module hcsp_scan
    import hcsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] ch,
    output logic       is_end,
    output color_t     color
);

    logic [CountW-1:0] cnt_reg;
    logic [CountW-1:0] cnt_next;
    logic              stop_reg;
    logic              stop_next;
    logic [7:0]        store_reg [StoreDepth];
    logic              wr_en;
    logic [IdxW-1:0]   wr_idx;
    logic [7:0]        wr_byte;
    hex_digit_t        dig;

    assign is_end = (ch == CharEnd);
    assign dig    = hex_decode(ch);
    assign wr_idx = cnt_reg[IdxW:1];

    always_comb
    begin
        cnt_next  = cnt_reg;
        stop_next = stop_reg;
        wr_en     = 1'b0;
        wr_byte   = {4'h0, dig.nib};
        if (cnt_reg[0])
        begin
            wr_byte = {store_reg[wr_idx][3:0], dig.nib};
        end
        if (step)
        begin
            if (is_end)
            begin
                cnt_next  = '0;
                stop_next = 1'b0;
            end
            else if (!stop_reg && cnt_reg < CntFull)
            begin
                if (dig.is_hex)
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + CountW'(1);
                end
                else
                begin
                    stop_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            stop_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            stop_reg <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_idx] <= wr_byte;
        end
    end

    // classify the digit count, rounding down to a form
    always_comb
    begin
        color.status = ST_OK;
        color.red    = {store_reg[0], store_reg[0]};
        color.green  = {store_reg[1], store_reg[1]};
        color.blue   = {store_reg[2], store_reg[2]};
        color.alpha  = AlphaOpaque;
        if (cnt_reg < CntShort)
        begin
            color.status = ST_SHORT;
            color.red    = '0;
            color.green  = '0;
            color.blue   = '0;
            color.alpha  = '0;
        end
        else if (cnt_reg < CntByteA)
        begin
            color.alpha = AlphaOpaque;
        end
        else if (cnt_reg < CntWide)
        begin
            color.alpha = {store_reg[3], store_reg[3]};
        end
        else
        begin
            color.red   = {store_reg[0], store_reg[1]};
            color.green = {store_reg[2], store_reg[3]};
            color.blue  = {store_reg[4], store_reg[5]};
            if (cnt_reg >= CntFull)
            begin
                color.alpha = {store_reg[6], store_reg[7]};
            end
        end
    end

endmodule

// File: sv/hcsp_obuf.sv
module hcsp_obuf
    import hcsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  color_t color,
    output logic   free,
    output logic   color_valid,
    input  logic   color_ready,
    output color_t color_q
);

    logic   valid_reg;
    logic   valid_next;
    color_t data_reg;

    assign free        = !valid_reg || color_ready;
    assign color_valid = valid_reg;
    assign color_q     = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (color_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= color;
        end
    end

endmodule

// File: sv/hex_color_string_parser.sv
// channel  dir  signals                                  word
// char     in   char_valid, char_ready, ch               one string character
// color    out  color_valid, color_ready, status, red,   one parsed color
//               green, blue, alpha
//
// one character per cycle unless a terminator waits; characters pass through the input register
// a terminator's color goes from the input register into the output register
// no color for other characters, and those never wait on the output side
// a terminator waits in the input register while the output register is full
// reset clears the digit count, scan stop and both valid flags
module hex_color_string_parser
    import hcsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  ch,
    output logic        color_valid,
    input  logic        color_ready,
    output logic        status,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue,
    output logic [15:0] alpha
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] ch_reg;
    logic       is_end;
    logic       out_free;
    logic       advance;
    color_t     color;
    color_t     color_q;

    assign advance    = in_valid_reg && (!is_end || out_free);
    assign char_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (char_valid && char_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            ch_reg <= ch;
        end
    end

    hcsp_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ch     (ch_reg),
        .is_end (is_end),
        .color  (color)
    );

    hcsp_obuf u_obuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && is_end),
        .color       (color),
        .free        (out_free),
        .color_valid (color_valid),
        .color_ready (color_ready),
        .color_q     (color_q)
    );

    assign status = color_q.status;
    assign red    = color_q.red;
    assign green  = color_q.green;
    assign blue   = color_q.blue;
    assign alpha  = color_q.alpha;

endmodule

// File: sv/hcsp_checker.sv
module hcsp_checker
    import hcsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        char_valid,
    input logic        char_ready,
    input logic [7:0]  ch,
    input logic        color_valid,
    input logic        color_ready,
    input logic        status,
    input logic [15:0] red,
    input logic [15:0] green,
    input logic [15:0] blue,
    input logic [15:0] alpha
);

    // input stalls only behind a full output
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !char_ready |-> color_valid)
        else $error("char stalled with empty output");

    // short string gives all-zero channels
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (color_valid && status) |-> (red == 16'h0 && green == 16'h0 &&
                                     blue == 16'h0 && alpha == 16'h0))
        else $error("error word with nonzero channel");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_ready) |=> (char_valid && $stable(ch)))
        else $error("stalled char word changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (color_valid && !color_ready) |=> color_valid)
        else $error("color word dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (color_valid && !color_ready) |=> ($stable(status) && $stable(red) &&
            $stable(green) && $stable(blue) && $stable(alpha)))
        else $error("stalled color word changed");

endmodule

bind hex_color_string_parser hcsp_checker u_hcsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .ch          (ch),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .status      (status),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha)
);

// File: sim/tb_top.sv
module tb_top
    import hcsp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandChars  = 1550;
    localparam int CalmChars  = 1350;
    localparam int LongHold   = 300;
    localparam int StallLimit = 5000;
    localparam int DrainWait  = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        color_t     col;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    logic [7:0]  ch = 8'h00;
    logic        color_valid;
    logic        color_ready = 1'b0;
    logic        status;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;

    // predictor state
    logic [7:0]  packed_bytes [StoreDepth];
    logic [4:0]  n_digits = '0;
    bit          scan_halted = 1'b0;

    color_t      colors_due [$];
    dir_row_t    dir_rows [$];
    int          errors = 0;
    int          sent = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_rx = 1'b0;

    hex_color_string_parser uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .ch          (ch),
        .color_valid (color_valid),
        .color_ready (color_ready),
        .status      (status),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // bit 4 set when the character is a hex digit
    function automatic logic [4:0] nib_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return 5'h00;
    endfunction

    function automatic logic [7:0] rand_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            return 8'(8'h61 + v - 10);
        end
        return 8'(8'h41 + v - 10);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [4:0] d;
        do
        begin
            c = 8'($urandom_range(1, 255));
            d = nib_of(c);
        end
        while (d[4]);
        return c;
    endfunction

    task automatic parse_char(input logic [7:0] c, output bit done, output color_t col);
        logic [4:0] d;
        logic [2:0] idx;
        done = 1'b0;
        col = '0;
        col.status = ST_OK;
        if (c != CharEnd)
        begin
            if (!scan_halted && n_digits < MaxDigits)
            begin
                d = nib_of(c);
                if (!d[4])
                begin
                    scan_halted = 1'b1;
                end
                else
                begin
                    idx = n_digits[3:1];
                    if (n_digits[0])
                    begin
                        packed_bytes[idx] = {packed_bytes[idx][3:0], d[3:0]};
                    end
                    else
                    begin
                        packed_bytes[idx] = {4'h0, d[3:0]};
                    end
                    n_digits = n_digits + 5'd1;
                end
            end
            return;
        end
        done = 1'b1;
        if (n_digits < CntShort)
        begin
            col.status = ST_SHORT;
        end
        else if (n_digits < CntWide)
        begin
            col.red   = {packed_bytes[0], packed_bytes[0]};
            col.green = {packed_bytes[1], packed_bytes[1]};
            col.blue  = {packed_bytes[2], packed_bytes[2]};
            col.alpha = (n_digits < CntByteA) ? AlphaOpaque
                                              : {packed_bytes[3], packed_bytes[3]};
        end
        else
        begin
            col.red   = {packed_bytes[0], packed_bytes[1]};
            col.green = {packed_bytes[2], packed_bytes[3]};
            col.blue  = {packed_bytes[4], packed_bytes[5]};
            col.alpha = (n_digits < CntFull) ? AlphaOpaque
                                             : {packed_bytes[6], packed_bytes[7]};
        end
        n_digits = '0;
        scan_halted = 1'b0;
    endtask

    task automatic send_char(input logic [7:0] c, input bit may_idle, input bit typed,
                             input color_t typed_col);
        int gap;
        bit done;
        color_t col;
        if (may_idle && !calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            char_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        char_valid <= 1'b1;
        ch <= c;
        @(posedge clk);
        while (!char_ready) @(posedge clk);
        parse_char(c, done, col);
        if (done)
        begin
            colors_due.push_back(typed ? typed_col : col);
        end
        sent++;
    endtask

    task automatic add_text(input string s);
        dir_row_t r;
        for (int i = 0; i < s.len(); i++)
        begin
            r = '0;
            r.ch = s[i];
            dir_rows.push_back(r);
        end
    endtask

    task automatic add_row(input logic [7:0] c, input bit typed, input color_t col);
        dir_row_t r;
        r.ch = c;
        r.typed = typed;
        r.col = col;
        dir_rows.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // receiver: random stalls, ready stretches, one long hold-off
    initial
    begin
        int k;
        wait (rst_n);
        forever
        begin
            if (hold_rx)
            begin
                @(negedge clk);
                color_ready <= 1'b0;
                repeat (LongHold - 1) @(negedge clk);
                hold_rx = 1'b0;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                k = $urandom_range(1, 7);
                @(negedge clk);
                color_ready <= 1'b0;
                repeat (k - 1) @(negedge clk);
            end
            else
            begin
                k = $urandom_range(1, 20);
                @(negedge clk);
                color_ready <= 1'b1;
                repeat (k - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : color_check
        color_t want;
        if (rst_n && color_valid && color_ready)
        begin
            if (colors_due.size() == 0)
            begin
                $display("%0t: unexpected word, actual %b %h %h %h %h",
                         $time, status, red, green, blue, alpha);
                errors++;
            end
            else
            begin
                want = colors_due.pop_front();
                check_field("status", 16'(want.status), 16'(status));
                check_field("red", want.red, red);
                check_field("green", want.green, green);
                check_field("blue", want.blue, blue);
                check_field("alpha", want.alpha, alpha);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && char_ready) || (color_valid && color_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        color_t     err_col;
        color_t     white_col;
        color_t     none;
        logic [7:0] str [$];
        int         strings;
        int         kind;
        int         n;
        bit         quiet;

        err_col = '0;
        err_col.status = ST_SHORT;
        white_col = '{ST_OK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        none = '0;

        // empty string
        add_row(CharEnd, 1'b1, err_col);
        // short, stopped by 0xff, rest ignored
        add_text("fF9");
        add_row(8'hFF, 1'b0, none);
        add_text("1");
        add_row(CharEnd, 1'b1, err_col);
        // eight digit form, mixed case
        add_text("aBcDeF01");
        add_row(CharEnd, 1'b0, none);
        // sixteen digit form, extra digit ignored
        add_text("FFFFFFFFFFFFFFFF1");
        add_row(CharEnd, 1'b1, white_col);

        wait (rst_n);
        foreach (dir_rows[i])
        begin
            send_char(dir_rows[i].ch, 1'b0, dir_rows[i].typed, dir_rows[i].col);
        end

        strings = 0;
        while (sent < RandChars)
        begin
            if (strings == 25)
            begin
                hold_rx = 1'b1;
            end
            if (strings == 60)
            begin
                @(negedge clk);
                char_valid <= 1'b0;
                while (colors_due.size() != 0) @(posedge clk);
            end
            calm = (sent > CalmChars);
            quiet = ($urandom_range(0, 3) == 0);
            str.delete();
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                n = $urandom_range(1, 12);
                repeat (n) str.push_back(8'($urandom_range(1, 255)));
            end
            else
            begin
                case ($urandom_range(0, 8))
                    0, 1:    n = 6;
                    2, 3:    n = 8;
                    4:       n = 12;
                    5, 6:    n = 16;
                    default: n = $urandom_range(0, 18);
                endcase
                repeat (n) str.push_back(rand_digit());
                if ($urandom_range(0, 2) == 0)
                begin
                    str.push_back(rand_non_hex());
                    n = $urandom_range(0, 4);
                    repeat (n) str.push_back(8'($urandom_range(1, 255)));
                end
            end
            str.push_back(CharEnd);
            foreach (str[i])
            begin
                send_char(str[i], !quiet, 1'b0, none);
            end
            strings++;
        end

        @(negedge clk);
        char_valid <= 1'b0;
        while (colors_due.size() != 0) @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
